// ----- hdl/sswr_pkg.sv -----
`timescale 1ns / 1ps

package sswr_pkg;

    // payload widths
    localparam int CMD_W       = 3;
    localparam int DATA_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int DEPTH_OUT_W = 9;

    // default number of stack entries
    localparam int DEPTH_DEFAULT = 256;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 3'd0,
        CMD_POP  = 3'd1,
        CMD_SWAP = 3'd2,
        CMD_ROTL = 3'd3,
        CMD_ROTR = 3'd4
    } cmd_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 2'd0,
        STAT_POP_EMPTY  = 2'd1,
        STAT_SWAP_SHORT = 2'd2,
        STAT_PUSH_FULL  = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture the incoming request
        logic rd_en;   // issue the memory read of the operation
        logic commit;  // write back, update pointers and load the result
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic needs_read;  // the held request reads an entry below the top
    } dp_status_t;

endpackage

// ----- hdl/sswr_in_if.sv -----
`timescale 1ns / 1ps

interface sswr_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [sswr_pkg::CMD_W-1:0]             cmd;
    logic signed [sswr_pkg::DATA_W-1:0]     push_value;

    modport source (output valid, cmd, push_value, input ready);
    modport sink   (input valid, cmd, push_value, output ready);
endinterface

// ----- hdl/sswr_out_if.sv -----
`timescale 1ns / 1ps

interface sswr_out_if;
    logic                                   valid;
    logic                                   ready;
    logic [sswr_pkg::STATUS_W-1:0]          status;
    logic signed [sswr_pkg::DATA_W-1:0]     top_value;
    logic                                   top_valid;
    logic [sswr_pkg::DEPTH_OUT_W-1:0]       depth_now;

    modport source (output valid, status, top_value, top_valid, depth_now, input ready);
    modport sink   (input valid, status, top_value, top_valid, depth_now, output ready);
endinterface

// ----- hdl/sswr_ram.sv -----
`timescale 1ns / 1ps

module sswr_ram #(
    parameter int WIDTH = sswr_pkg::DATA_W,
    parameter int DEPTH = sswr_pkg::DEPTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single port, registered read, read data held while idle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/sswr_ctrl.sv -----
`timescale 1ns / 1ps

module sswr_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    output logic                   res_valid,
    input  logic                   res_ready,
    input  sswr_pkg::dp_status_t   st,
    output sswr_pkg::ctrl_cmd_t    ctl
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_READ   = 3'b010,
        S_COMMIT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   res_valid_reg;
    logic   res_valid_next;
    logic   slot_free;
    logic   accept;

    // result register can take a new result this cycle
    assign slot_free = !res_valid_reg || res_ready;

    assign req_ready = (state_reg == S_IDLE) || ((state_reg == S_COMMIT) && slot_free);
    assign accept    = req_valid && req_ready;

    // commands to the datapath
    always_comb
    begin
        ctl        = '0;
        ctl.load   = accept;
        ctl.rd_en  = (state_reg == S_READ) && st.needs_read;
        ctl.commit = (state_reg == S_COMMIT) && slot_free;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (slot_free)
                begin
                    state_next = req_valid ? S_READ : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        if (ctl.commit)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;

endmodule

// ----- hdl/sswr_dp.sv -----
`timescale 1ns / 1ps

module sswr_dp #(
    parameter int DEPTH = sswr_pkg::DEPTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sswr_pkg::ctrl_cmd_t                   ctl,
    output sswr_pkg::dp_status_t                  st,
    input  logic [sswr_pkg::CMD_W-1:0]            cmd,
    input  logic signed [sswr_pkg::DATA_W-1:0]    push_value,
    output logic [sswr_pkg::STATUS_W-1:0]         status,
    output logic signed [sswr_pkg::DATA_W-1:0]    top_value,
    output logic                                  top_valid,
    output logic [sswr_pkg::DEPTH_OUT_W-1:0]      depth_now
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = sswr_pkg::DATA_W;

    // (a - b) mod DEPTH for b up to DEPTH
    function automatic logic [AW-1:0] pos_back(input logic [AW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] sum;
        sum = (CW+1)'(a) + (CW+1)'(DEPTH) - (CW+1)'(b);
        if (sum >= (CW+1)'(DEPTH))
        begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return AW'(sum);
    endfunction

    // (a + 1) mod DEPTH
    function automatic logic [AW-1:0] pos_next(input logic [AW-1:0] a);
        logic [AW-1:0] r;
        r = (a == AW'(DEPTH - 1)) ? '0 : a + 1'b1;
        return r;
    endfunction

    // the top entry lives in top_reg; memory holds the entries below it
    logic [sswr_pkg::CMD_W-1:0] cmd_reg;
    logic [DW-1:0]              val_reg;
    logic [AW-1:0]              tidx_reg;
    logic [AW-1:0]              tidx_next;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;
    logic [DW-1:0]              top_reg;
    logic [DW-1:0]              top_next;

    logic [sswr_pkg::STATUS_W-1:0] status_reg;
    logic [DW-1:0]                 top_value_reg;
    logic                          top_valid_reg;
    logic [sswr_pkg::DEPTH_OUT_W-1:0] depth_reg;

    logic          is_full;
    logic          is_empty;
    logic          has_two;
    logic          act_push;
    logic          act_pop;
    logic          act_swap;
    logic          act_rotl;
    logic          act_rotr;
    logic          wr_act;
    sswr_pkg::status_t stat;
    logic [AW-1:0] below_addr;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          ram_en;
    logic [AW-1:0] ram_addr;
    logic [DW-1:0] ram_rdata;

    // request capture
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd;
            val_reg <= push_value;
        end
    end

    // decode of the held request against the stack occupancy
    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign has_two  = (count_reg > CW'(1));

    always_comb
    begin
        act_push = 1'b0;
        act_pop  = 1'b0;
        act_swap = 1'b0;
        act_rotl = 1'b0;
        act_rotr = 1'b0;
        stat     = sswr_pkg::STAT_OK;
        unique case (cmd_reg)
            sswr_pkg::CMD_PUSH:
            begin
                act_push = !is_full;
                stat     = is_full ? sswr_pkg::STAT_PUSH_FULL : sswr_pkg::STAT_OK;
            end
            sswr_pkg::CMD_POP:
            begin
                act_pop = !is_empty;
                stat    = is_empty ? sswr_pkg::STAT_POP_EMPTY : sswr_pkg::STAT_OK;
            end
            sswr_pkg::CMD_SWAP:
            begin
                act_swap = has_two;
                stat     = has_two ? sswr_pkg::STAT_OK : sswr_pkg::STAT_SWAP_SHORT;
            end
            sswr_pkg::CMD_ROTL:
            begin
                act_rotl = has_two;
            end
            sswr_pkg::CMD_ROTR:
            begin
                act_rotr = has_two;
            end
            default:
            begin
                stat = sswr_pkg::STAT_OK;
            end
        endcase
    end

    assign st.needs_read = act_pop || act_swap || act_rotl || act_rotr;
    assign wr_act        = act_push || act_swap || act_rotl || act_rotr;

    // memory addresses
    assign below_addr = pos_back(tidx_reg, CW'(1));
    assign rd_addr    = act_rotr ? pos_back(tidx_reg, count_reg - 1'b1) : below_addr;

    always_comb
    begin
        priority if (act_swap)
        begin
            wr_addr = below_addr;
        end
        else if (act_rotl)
        begin
            wr_addr = pos_back(tidx_reg, count_reg);
        end
        else
        begin
            wr_addr = tidx_reg;
        end
    end

    assign ram_en   = ctl.rd_en || (ctl.commit && wr_act);
    assign ram_addr = ctl.commit ? wr_addr : rd_addr;

    sswr_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ctl.commit),
        .addr  (ram_addr),
        .wdata (top_reg),
        .rdata (ram_rdata)
    );

    // pointer, count and top update
    always_comb
    begin
        tidx_next  = tidx_reg;
        count_next = count_reg;
        top_next   = top_reg;
        priority if (act_push)
        begin
            tidx_next  = pos_next(tidx_reg);
            count_next = count_reg + 1'b1;
            top_next   = val_reg;
        end
        else if (act_pop)
        begin
            tidx_next  = below_addr;
            count_next = count_reg - 1'b1;
            top_next   = ram_rdata;
        end
        else if (act_swap)
        begin
            top_next = ram_rdata;
        end
        else if (act_rotl)
        begin
            tidx_next = below_addr;
            top_next  = ram_rdata;
        end
        else if (act_rotr)
        begin
            tidx_next = pos_next(tidx_reg);
            top_next  = ram_rdata;
        end
        else
        begin
            // refused, short or unknown requests leave the stack as it is
            tidx_next = tidx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tidx_reg  <= '0;
            count_reg <= '0;
        end
        else if (ctl.commit)
        begin
            tidx_reg  <= tidx_next;
            count_reg <= count_next;
        end
    end

    // top entry and result register
    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            top_reg       <= top_next;
            status_reg    <= stat;
            top_value_reg <= (count_next != '0) ? top_next : '0;
            top_valid_reg <= (count_next != '0);
            depth_reg     <= sswr_pkg::DEPTH_OUT_W'(count_next);
        end
    end

    assign status    = status_reg;
    assign top_value = top_value_reg;
    assign top_valid = top_valid_reg;
    assign depth_now = depth_reg;

endmodule

// ----- hdl/stack_with_swap_and_rotate_unit.sv -----
`timescale 1ns / 1ps

// Bounded LIFO stack with swap and rotate for a stack-machine interpreter.
// cmd_ch carries one request: a command (push, pop, swap, rotate left,
// rotate right) and the value to push. res_ch returns exactly one result per
// request: status, the new top value (zero when empty), top_valid and depth.
// Both channels use valid/ready; a request or result moves when both are high.
// An accepted request passes through a read state, which issues the memory
// read that its command needs, and a write-back state, which writes memory
// and loads the result register. The single-port entry memory takes that
// one read and one write, so a new request waits for the write-back state.
// The top entry is held in a register, so no command needs more than one
// read and one write. The next request is accepted in the write-back cycle.
// A finished result waits in the output register while a request is accepted;
// if the receiver stalls, the following request holds in write-back until
// the output register frees. Reset (rst_n, asynchronous, active low) empties
// the stack and drops any pending result; entry memory is not cleared.
module stack_with_swap_and_rotate_unit #(
    parameter int DEPTH = sswr_pkg::DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    sswr_in_if.sink    cmd_ch,
    sswr_out_if.source res_ch
);

    sswr_pkg::ctrl_cmd_t  ctl;
    sswr_pkg::dp_status_t st;

    // sequencing
    sswr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (cmd_ch.valid),
        .req_ready (cmd_ch.ready),
        .res_valid (res_ch.valid),
        .res_ready (res_ch.ready),
        .st        (st),
        .ctl       (ctl)
    );

    // stack storage and result
    sswr_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .st         (st),
        .cmd        (cmd_ch.cmd),
        .push_value (cmd_ch.push_value),
        .status     (res_ch.status),
        .top_value  (res_ch.top_value),
        .top_valid  (res_ch.top_valid),
        .depth_now  (res_ch.depth_now)
    );

    // a request is never taken in the cycle right after another
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ch.valid && cmd_ch.ready |=> !cmd_ch.ready)
        else $error("request accepted during memory read");

    // a write-back always leaves a result on offer
    a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |=> res_ch.valid)
        else $error("write-back without result");

    // a refused push means the stack is full, hence not empty
    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_ch.valid && (res_ch.status == sswr_pkg::STAT_PUSH_FULL) |-> res_ch.top_valid)
        else $error("push refused on a stack that is not full");

    // a refused pop means the stack is empty
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_ch.valid && (res_ch.status == sswr_pkg::STAT_POP_EMPTY) |->
            !res_ch.top_valid && (res_ch.depth_now == '0))
        else $error("pop refused on a stack that holds entries");

endmodule

// ----- tb/sv/tb_stack_with_swap_and_rotate_unit.sv -----
`timescale 1ns / 1ps

module tb_stack_with_swap_and_rotate_unit;

    localparam int CMD_W        = sswr_pkg::CMD_W;
    localparam int DATA_W       = sswr_pkg::DATA_W;
    localparam int STATUS_W     = sswr_pkg::STATUS_W;
    localparam int DEPTH_OUT_W  = sswr_pkg::DEPTH_OUT_W;
    localparam int STACK_SLOTS  = sswr_pkg::DEPTH_DEFAULT;
    localparam int RANDOM_REQS  = 700;
    localparam int FILL_AFTER   = 250;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_AFTER   = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] value;
    } stack_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [DATA_W-1:0]      top_value;
        logic                   top_valid;
        logic [DEPTH_OUT_W-1:0] depth_now;
    } stack_res_t;

    // receiver ready styles
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_PATTERN,
        RX_SPARSE
    } rx_style_t;

    logic clk;
    logic rst_n;

    sswr_in_if  cmd_if ();
    sswr_out_if res_if ();

    stack_with_swap_and_rotate_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_ch (cmd_if),
        .res_ch (res_if)
    );

    // pending requests and the results they should produce
    stack_req_t req_q[$];
    stack_res_t expected_results[$];

    // predicted stack contents
    logic [DATA_W-1:0] model_mem [STACK_SLOTS];
    int unsigned       model_top;
    int unsigned       model_count;

    int gen_depth;
    int n_generated;
    int n_reqs;
    int n_results;
    int n_fail;
    int n_reported;
    int n_pop_empty;
    int n_swap_short;
    int n_push_full;
    int max_depth_seen;
    int idle_cycles;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // position b slots below a, wrapping round the store
    function automatic int unsigned slot_back(int unsigned a, int unsigned b);
        return (a + STACK_SLOTS - b) % STACK_SLOTS;
    endfunction

    // apply one request to the predicted stack and return its result
    function automatic stack_res_t predict_stack(stack_req_t req);
        stack_res_t        res;
        int unsigned       t;
        int unsigned       s;
        logic [DATA_W-1:0] held;
        res.status = sswr_pkg::STAT_OK;
        t = model_top;
        case (req.cmd)
            sswr_pkg::CMD_PUSH:
            begin
                if (model_count >= STACK_SLOTS)
                    res.status = sswr_pkg::STAT_PUSH_FULL;
                else
                begin
                    t = (t + 1) % STACK_SLOTS;
                    model_mem[t] = req.value;
                    model_count++;
                end
            end
            sswr_pkg::CMD_POP:
            begin
                if (model_count == 0)
                    res.status = sswr_pkg::STAT_POP_EMPTY;
                else
                begin
                    t = slot_back(t, 1);
                    model_count--;
                end
            end
            sswr_pkg::CMD_SWAP:
            begin
                if (model_count < 2)
                    res.status = sswr_pkg::STAT_SWAP_SHORT;
                else
                begin
                    s = slot_back(t, 1);
                    held = model_mem[t];
                    model_mem[t] = model_mem[s];
                    model_mem[s] = held;
                end
            end
            sswr_pkg::CMD_ROTL:
            begin
                // top entry drops below the bottom
                if (model_count >= 2)
                begin
                    model_mem[slot_back(t, model_count)] = model_mem[t];
                    t = slot_back(t, 1);
                end
            end
            sswr_pkg::CMD_ROTR:
            begin
                // bottom entry moves above the top
                if (model_count >= 2)
                begin
                    s = (t + 1) % STACK_SLOTS;
                    model_mem[s] = model_mem[slot_back(t, model_count - 1)];
                    t = s;
                end
            end
            default:
            begin
            end
        endcase
        model_top = t;
        res.top_value = (model_count != 0) ? model_mem[t] : '0;
        res.top_valid = (model_count != 0);
        res.depth_now = model_count[DEPTH_OUT_W-1:0];
        return res;
    endfunction

    // queue a request, keeping track of the depth it leads to
    task automatic add_req(input logic [CMD_W-1:0] c, input logic [DATA_W-1:0] v);
        stack_req_t r;
        r.cmd = c;
        r.value = v;
        req_q.push_back(r);
        n_generated++;
        if (c == sswr_pkg::CMD_PUSH && gen_depth < STACK_SLOTS)
            gen_depth++;
        else if (c == sswr_pkg::CMD_POP && gen_depth > 0)
            gen_depth--;
    endtask

    // push value with the extremes mixed in
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '1;
            3:       return '0;
            default: return $urandom();
        endcase
    endfunction

    // command with a given share of pushes, the odd unused code included
    function automatic logic [CMD_W-1:0] pick_cmd(int push_pct);
        if ($urandom_range(0, 99) < push_pct)
            return sswr_pkg::CMD_PUSH;
        case ($urandom_range(0, 12))
            0, 1, 2:   return sswr_pkg::CMD_POP;
            3, 4, 5:   return sswr_pkg::CMD_SWAP;
            6, 7, 8:   return sswr_pkg::CMD_ROTL;
            9, 10, 11: return sswr_pkg::CMD_ROTR;
            default:   return CMD_W'($urandom_range(5, 7));
        endcase
    endfunction

    // request driver: bursts of random length with random gaps
    stack_req_t req_on_bus;
    int         burst_left;
    int         gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_if.valid      <= 1'b0;
            cmd_if.cmd        <= '0;
            cmd_if.push_value <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            // request taken at this edge
            if (cmd_if.valid && cmd_if.ready)
            begin
                expected_results.push_back(predict_stack(req_on_bus));
                n_reqs++;
            end
            // bus free: offer the next request or idle
            if (!cmd_if.valid || cmd_if.ready)
            begin
                if (burst_left > 0 && req_q.size() > 0)
                begin
                    req_on_bus = req_q.pop_front();
                    cmd_if.cmd        <= req_on_bus.cmd;
                    cmd_if.push_value <= req_on_bus.value;
                    cmd_if.valid      <= 1'b1;
                    burst_left--;
                end
                else
                begin
                    cmd_if.valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                                 : $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // result monitor and receiver stall pattern
    stack_res_t got_res;
    stack_res_t want_res;
    rx_style_t  rx_style;
    int         rx_left;
    int         rx_phase;
    int         hold_left;
    bit         hold_done;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            rx_style  = RX_OPEN;
            rx_left   = 0;
            rx_phase  = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            // check a result against the oldest prediction
            if (res_if.valid && res_if.ready)
            begin
                got_res.status    = res_if.status;
                got_res.top_value = res_if.top_value;
                got_res.top_valid = res_if.top_valid;
                got_res.depth_now = res_if.depth_now;
                if (expected_results.size() == 0)
                begin
                    n_fail++;
                    if (n_reported < MAX_REPORTS)
                    begin
                        $display("unexpected result: status %0d top %h valid %0b depth %0d",
                                 got_res.status, got_res.top_value, got_res.top_valid,
                                 got_res.depth_now);
                        n_reported++;
                    end
                end
                else
                begin
                    want_res = expected_results.pop_front();
                    n_results++;
                    if (want_res.status == sswr_pkg::STAT_POP_EMPTY)
                        n_pop_empty++;
                    if (want_res.status == sswr_pkg::STAT_SWAP_SHORT)
                        n_swap_short++;
                    if (want_res.status == sswr_pkg::STAT_PUSH_FULL)
                        n_push_full++;
                    if (int'(want_res.depth_now) > max_depth_seen)
                        max_depth_seen = want_res.depth_now;
                    if (got_res !== want_res)
                    begin
                        n_fail++;
                        if (n_reported < MAX_REPORTS)
                        begin
                            $display("mismatch on result %0d: expected status %0d top %h",
                                     n_results, want_res.status, want_res.top_value,
                                     " valid %0b depth %0d", want_res.top_valid,
                                     want_res.depth_now);
                            $display("    got status %0d top %h valid %0b depth %0d",
                                     got_res.status, got_res.top_value,
                                     got_res.top_valid, got_res.depth_now);
                            n_reported++;
                        end
                    end
                end
            end
            // one long hold-off so the block backs up and stalls its input
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else if (!hold_done && n_results >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                res_if.ready <= 1'b0;
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_style = rx_style_t'($urandom_range(0, 3));
                    rx_left  = $urandom_range(16, 96);
                end
                rx_left--;
                rx_phase++;
                case (rx_style)
                    RX_OPEN:    res_if.ready <= 1'b1;
                    RX_COIN:    res_if.ready <= $urandom_range(0, 1);
                    RX_PATTERN: res_if.ready <= (rx_phase % 4) != 0;
                    default:    res_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // watchdog on cycles with nothing moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: nothing moved for %0d cycles, %0d of %0d requests taken",
                         idle_cycles, n_reqs, n_generated);
                $display("stack_with_swap_and_rotate_unit verification failed");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        int  seg_len;
        int  push_pct;
        bit  filled;
        rst_n             = 1'b0;
        cmd_if.valid      = 1'b0;
        cmd_if.cmd        = '0;
        cmd_if.push_value = '0;
        res_if.ready      = 1'b0;
        model_top         = 0;
        model_count       = 0;
        gen_depth         = 0;
        n_generated       = 0;
        n_reqs            = 0;
        n_results         = 0;
        n_fail            = 0;
        n_reported        = 0;
        n_pop_empty       = 0;
        n_swap_short      = 0;
        n_push_full       = 0;
        max_depth_seen    = 0;
        idle_cycles       = 0;
        filled            = 1'b0;

        // directed: everything on an empty stack, then one entry, then a few
        add_req(sswr_pkg::CMD_POP, pick_value());
        add_req(sswr_pkg::CMD_SWAP, pick_value());
        add_req(sswr_pkg::CMD_ROTL, pick_value());
        add_req(sswr_pkg::CMD_ROTR, pick_value());
        add_req(CMD_W'(5), '0);
        add_req(CMD_W'(6), 32'h5555_5555);
        add_req(CMD_W'(7), '1);
        add_req(sswr_pkg::CMD_PUSH, 32'h7FFF_FFFF);
        add_req(sswr_pkg::CMD_SWAP, '0);
        add_req(sswr_pkg::CMD_ROTL, '0);
        add_req(sswr_pkg::CMD_ROTR, '0);
        add_req(sswr_pkg::CMD_POP, '0);
        add_req(sswr_pkg::CMD_PUSH, 32'h8000_0000);
        add_req(sswr_pkg::CMD_PUSH, '1);
        add_req(sswr_pkg::CMD_PUSH, '0);
        add_req(sswr_pkg::CMD_SWAP, '0);
        add_req(sswr_pkg::CMD_ROTL, '0);
        add_req(sswr_pkg::CMD_ROTR, '0);
        add_req(sswr_pkg::CMD_PUSH, 32'hAAAA_AAAA);
        add_req(sswr_pkg::CMD_ROTR, '0);
        add_req(sswr_pkg::CMD_POP, '0);
        add_req(sswr_pkg::CMD_POP, '0);
        add_req(sswr_pkg::CMD_POP, '0);
        add_req(sswr_pkg::CMD_POP, '0);
        add_req(sswr_pkg::CMD_POP, '0);

        // random: mostly mixed runs, plus drains, short shuffles and one fill
        while (n_generated < RANDOM_REQS + 25)
        begin
            if (!filled && n_generated > FILL_AFTER)
            begin
                filled = 1'b1;
                while (gen_depth < STACK_SLOTS)
                    add_req(sswr_pkg::CMD_PUSH, pick_value());
                repeat ($urandom_range(1, 3))
                    add_req(sswr_pkg::CMD_PUSH, pick_value());
                add_req(sswr_pkg::CMD_SWAP, pick_value());
                add_req(sswr_pkg::CMD_ROTL, pick_value());
                add_req(sswr_pkg::CMD_ROTR, pick_value());
                add_req(sswr_pkg::CMD_ROTR, pick_value());
                add_req(sswr_pkg::CMD_ROTL, pick_value());
                add_req(sswr_pkg::CMD_PUSH, pick_value());
                repeat ($urandom_range(5, 20))
                    add_req(pick_cmd(20), pick_value());
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5:
                    begin
                        seg_len  = $urandom_range(10, 40);
                        push_pct = $urandom_range(25, 70);
                        repeat (seg_len)
                            add_req(pick_cmd(push_pct), pick_value());
                    end
                    6:
                    begin
                        // drain to empty and poke the empty stack
                        while (gen_depth > 0)
                            add_req(sswr_pkg::CMD_POP, pick_value());
                        repeat ($urandom_range(1, 3))
                            add_req(sswr_pkg::CMD_POP, pick_value());
                        add_req(sswr_pkg::CMD_SWAP, pick_value());
                        add_req(sswr_pkg::CMD_ROTL, pick_value());
                        add_req(sswr_pkg::CMD_ROTR, pick_value());
                    end
                    7, 8:
                    begin
                        // short stack shuffled by swaps and rotates
                        repeat ($urandom_range(2, 5))
                            add_req(sswr_pkg::CMD_PUSH, pick_value());
                        repeat ($urandom_range(4, 12))
                            add_req(pick_cmd(0), pick_value());
                    end
                    default:
                    begin
                        // raw noise over the whole command field
                        repeat ($urandom_range(3, 10))
                            add_req(CMD_W'($urandom()), $urandom());
                    end
                endcase
            end
        end

        // reset once, then let the driver run
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (n_reqs < n_generated || expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_results.size() > 0)
        begin
            n_fail++;
            $display("%0d expected results never arrived", expected_results.size());
        end

        $display("covered %0d requests and %0d results, peak depth %0d", n_reqs, n_results,
                 max_depth_seen);
        $display("pops on empty %0d, short swaps %0d, pushes when full %0d, failures %0d",
                 n_pop_empty, n_swap_short, n_push_full, n_fail);
        if (n_fail == 0)
            $display("stack_with_swap_and_rotate_unit verification clean");
        else
            $display("stack_with_swap_and_rotate_unit verification failed");
        $finish;
    end

endmodule
